// ----- sv/cbd_pkg.sv -----
// Shared types, codes and address decode for the CPU bus decoder.
package cbd_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_RETURN = 2'd3;

    // Downstream request kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Downstream targets
    localparam logic [1:0] TGT_RAM = 2'd0;
    localparam logic [1:0] TGT_PPU = 2'd1;
    localparam logic [1:0] TGT_APU = 2'd2;
    localparam logic [1:0] TGT_ROM = 2'd3;

    // Memory map boundaries
    localparam logic [15:0] ADDR_PPU      = 16'h2000;
    localparam logic [15:0] ADDR_APU      = 16'h4000;
    localparam logic [15:0] ADDR_OAM_DMA  = 16'h4014;
    localparam logic [15:0] ADDR_JOY1     = 16'h4016;
    localparam logic [15:0] ADDR_JOY2     = 16'h4017;
    localparam logic [15:0] ADDR_EMPTY    = 16'h4018;
    localparam logic [15:0] ADDR_WRAM     = 16'h6000;
    localparam logic [15:0] ADDR_ROM      = 16'h8000;
    localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
    localparam logic [7:0]  JOY_OPEN_BUS  = 8'h40;

    localparam int WORK_RAM_DEPTH = 8192;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [3:0] {
        RG_RAM,
        RG_PPU,
        RG_APU,
        RG_OAM_DMA,
        RG_JOY1,
        RG_JOY2,
        RG_EMPTY,
        RG_WRAM,
        RG_ROM
    } t_region;

    // One result item
    typedef struct packed {
        logic [1:0]  request_kind;
        logic [1:0]  target;
        logic [15:0] request_address;
        logic [7:0]  request_data;
        logic        local_valid;
        logic [7:0]  local_data;
        logic        dma_active;
    } t_result;

    function automatic t_region region_of(logic [15:0] a);
        t_region r;
        if (a < ADDR_PPU)              r = RG_RAM;
        else if (a < ADDR_APU)         r = RG_PPU;
        else if (a == ADDR_OAM_DMA)    r = RG_OAM_DMA;
        else if (a == ADDR_JOY1)       r = RG_JOY1;
        else if (a == ADDR_JOY2)       r = RG_JOY2;
        else if (a < ADDR_EMPTY)       r = RG_APU;
        else if (a < ADDR_WRAM)        r = RG_EMPTY;
        else if (a < ADDR_ROM)         r = RG_WRAM;
        else                           r = RG_ROM;
        return r;
    endfunction

    function automatic logic [1:0] target_of(t_region r);
        logic [1:0] t;
        unique case (r)
            RG_RAM:  t = TGT_RAM;
            RG_PPU:  t = TGT_PPU;
            RG_ROM:  t = TGT_ROM;
            default: t = TGT_APU;
        endcase
        return t;
    endfunction

endpackage

// ----- sv/cbd_if.sv -----
// Handshake interfaces for the input and result channels.
interface cbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  buttons;

    modport source(output valid, operation, address, write_data, buttons, input ready);
    modport sink(input valid, operation, address, write_data, buttons, output ready);
endinterface

interface cbd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  request_kind;
    logic [1:0]  target;
    logic [15:0] request_address;
    logic [7:0]  request_data;
    logic        local_valid;
    logic [7:0]  local_data;
    logic        dma_active;

    modport source(output valid, request_kind, target, request_address, request_data,
                   local_valid, local_data, dma_active, input ready);
    modport sink(input valid, request_kind, target, request_address, request_data,
                 local_valid, local_data, dma_active, output ready);
endinterface

// ----- sv/cbd_front.sv -----
// Front end: accepts items, decodes them, keeps controller/DMA state and work RAM.
module cbd_front #(
    parameter int WORK_RAM_DEPTH = cbd_pkg::WORK_RAM_DEPTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    cbd_in_if.sink                                   i_in,
    input  logic [$clog2(cbd_pkg::QUEUE_DEPTH+1)-1:0] i_queue_count,
    output logic                                     o_push,
    output cbd_pkg::t_result                         o_item
);

    localparam int AW = $clog2(WORK_RAM_DEPTH);
    localparam int CW = $clog2(cbd_pkg::QUEUE_DEPTH + 1);
    localparam logic [15:0] D1 = 16'(WORK_RAM_DEPTH);
    localparam logic [15:0] D2 = 16'(2 * WORK_RAM_DEPTH);
    localparam logic [15:0] D4 = 16'(4 * WORK_RAM_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(WORK_RAM_DEPTH - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_WRITE
    } t_phase;

    // Offset into work RAM folded by the depth; offset stays below eight depths
    function automatic logic [AW-1:0] wram_index(logic [15:0] a);
        logic [15:0] r;
        r = a - cbd_pkg::ADDR_WRAM;
        if (r >= D4) r = r - D4;
        if (r >= D2) r = r - D2;
        if (r >= D1) r = r - D1;
        return r[AW-1:0];
    endfunction

    logic [7:0]  r_mem [WORK_RAM_DEPTH];
    logic [7:0]  r_rd_data;
    logic        r_clearing;
    logic [AW-1:0] r_clr_idx;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_mask, n_mask;
    logic [15:0] r_src, n_src;
    logic [7:0]  r_dma_value, n_dma_value;
    logic        r_waiting, n_waiting;
    logic        r_val_pend, n_val_pend;

    logic             r_s1_valid;
    logic             r_s1_ram_sel;
    cbd_pkg::t_result r_s1_item;

    logic             accept;
    logic             room;
    logic [15:0]      rd_addr;
    cbd_pkg::t_region rd_region;
    cbd_pkg::t_region wr_region;
    logic             rd_down;
    logic [7:0]       rd_local;
    logic [7:0]       dma_value_eff;
    logic             ram_re, ram_we, ram_sel;
    logic [AW-1:0]    ram_idx, mem_idx;
    logic [7:0]       mem_wdata;
    logic             mem_we;
    cbd_pkg::t_result item;

    // Credit check: queue entries plus the item in the stage register
    assign room     = ({1'b0, i_queue_count} + {{CW{1'b0}}, r_s1_valid}) <
                      (CW+1)'(cbd_pkg::QUEUE_DEPTH);
    assign i_in.ready = !r_clearing && room;
    assign accept   = i_in.valid && i_in.ready;

    // Read-side decode, shared by cpu reads and DMA source reads
    assign rd_addr   = (i_in.operation == cbd_pkg::OP_TICK) ? r_src : i_in.address;
    assign rd_region = cbd_pkg::region_of(rd_addr);
    assign wr_region = cbd_pkg::region_of(i_in.address);
    assign dma_value_eff = r_val_pend ? r_rd_data : r_dma_value;

    always_comb begin
        rd_down  = 1'b0;
        rd_local = 8'h00;
        unique case (rd_region)
            cbd_pkg::RG_RAM, cbd_pkg::RG_PPU, cbd_pkg::RG_APU,
            cbd_pkg::RG_OAM_DMA, cbd_pkg::RG_ROM: begin
                rd_down = 1'b1;
            end
            cbd_pkg::RG_JOY1: begin
                rd_local = cbd_pkg::JOY_OPEN_BUS | {7'd0, |(i_in.buttons & r_mask)};
            end
            cbd_pkg::RG_JOY2: begin
                rd_local = cbd_pkg::JOY_OPEN_BUS;
            end
            default: begin
                rd_local = 8'h00;
            end
        endcase
    end

    // Next state and result of the accepted item
    always_comb begin
        n_phase     = r_phase;
        n_mask      = r_mask;
        n_src       = r_src;
        n_dma_value = dma_value_eff;
        n_waiting   = r_waiting;
        n_val_pend  = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_sel     = 1'b0;
        ram_idx     = wram_index(rd_addr);
        item        = '0;
        if (accept) begin
            unique case (i_in.operation)
                cbd_pkg::OP_READ: begin
                    if (rd_down) begin
                        item.request_kind    = cbd_pkg::KIND_READ;
                        item.target          = cbd_pkg::target_of(rd_region);
                        item.request_address = rd_addr;
                    end else begin
                        item.local_valid = 1'b1;
                        item.local_data  = rd_local;
                        if (rd_region == cbd_pkg::RG_JOY1) n_mask = {r_mask[6:0], 1'b0};
                        if (rd_region == cbd_pkg::RG_WRAM) begin
                            ram_re  = 1'b1;
                            ram_sel = 1'b1;
                        end
                    end
                end
                cbd_pkg::OP_WRITE: begin
                    unique case (wr_region)
                        cbd_pkg::RG_OAM_DMA: begin
                            n_src     = {i_in.write_data, 8'h00};
                            n_phase   = PH_READ;
                            n_waiting = 1'b0;
                        end
                        cbd_pkg::RG_JOY1: begin
                            if (!i_in.write_data[0]) n_mask = 8'h01;
                        end
                        cbd_pkg::RG_EMPTY: begin
                        end
                        cbd_pkg::RG_WRAM: begin
                            ram_we  = 1'b1;
                            ram_idx = wram_index(i_in.address);
                        end
                        default: begin
                            item.request_kind    = cbd_pkg::KIND_WRITE;
                            item.target          = cbd_pkg::target_of(wr_region);
                            item.request_address = i_in.address;
                            item.request_data    = i_in.write_data;
                        end
                    endcase
                end
                cbd_pkg::OP_TICK: begin
                    unique case (r_phase)
                        PH_READ: begin
                            if (rd_down) begin
                                item.request_kind    = cbd_pkg::KIND_READ;
                                item.target          = cbd_pkg::target_of(rd_region);
                                item.request_address = rd_addr;
                                n_waiting            = 1'b1;
                            end else begin
                                if (rd_region == cbd_pkg::RG_JOY1)
                                    n_mask = {r_mask[6:0], 1'b0};
                                if (rd_region == cbd_pkg::RG_WRAM) begin
                                    ram_re     = 1'b1;
                                    n_val_pend = 1'b1;
                                end else begin
                                    n_dma_value = rd_local;
                                end
                            end
                            n_src   = r_src + 16'd1;
                            n_phase = PH_WRITE;
                        end
                        PH_WRITE: begin
                            if (!r_waiting) begin
                                item.request_kind    = cbd_pkg::KIND_WRITE;
                                item.target          = cbd_pkg::TGT_PPU;
                                item.request_address = cbd_pkg::ADDR_OAM_DATA;
                                item.request_data    = dma_value_eff;
                                n_phase = (r_src[7:0] != 8'h00) ? PH_READ : PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    if (r_waiting) begin
                        n_dma_value = i_in.write_data;
                        n_waiting   = 1'b0;
                    end
                end
            endcase
            item.dma_active = (n_phase != PH_IDLE);
        end
    end

    // Work RAM port, shared with the clearing pass
    assign mem_we    = r_clearing || ram_we;
    assign mem_idx   = r_clearing ? r_clr_idx : ram_idx;
    assign mem_wdata = r_clearing ? 8'h00 : i_in.write_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_idx] <= mem_wdata;
        if (ram_re) r_rd_data <= r_mem[mem_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_idx   <= '0;
            r_phase     <= PH_IDLE;
            r_mask      <= 8'h00;
            r_src       <= 16'h0000;
            r_dma_value <= 8'h00;
            r_waiting   <= 1'b0;
            r_val_pend  <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + AW'(1);
                if (r_clr_idx == CLR_LAST) r_clearing <= 1'b0;
            end
            r_phase     <= n_phase;
            r_mask      <= n_mask;
            r_src       <= n_src;
            r_dma_value <= n_dma_value;
            r_waiting   <= n_waiting;
            r_val_pend  <= n_val_pend;
            r_s1_valid  <= accept;
        end
    end

    // Stage register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item    <= item;
            r_s1_ram_sel <= ram_sel;
        end
    end

    // Work RAM read data, registered at the access, joins the item in the cycle after it
    always_comb begin
        o_item = r_s1_item;
        if (r_s1_ram_sel) o_item.local_data = r_rd_data;
    end
    assign o_push = r_s1_valid;

endmodule

// ----- sv/cbd_queue.sv -----
// Short result queue between the front end and the output stage.
module cbd_queue (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    input  cbd_pkg::t_result                          i_item,
    input  logic                                      i_pop,
    output logic                                      o_valid,
    output cbd_pkg::t_result                          o_item,
    output logic [$clog2(cbd_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(cbd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(cbd_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(cbd_pkg::QUEUE_DEPTH - 1);

    cbd_pkg::t_result r_buf [cbd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_head, r_tail;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_head];
    assign o_count = r_count;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_tail] <= i_item;
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_tail <= (r_tail == LAST) ? '0 : r_tail + PW'(1);
            if (do_pop) r_head <= (r_head == LAST) ? '0 : r_head + PW'(1);
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

endmodule

// ----- sv/cbd_back.sv -----
// Output stage: drains the queue into a registered result channel.
module cbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cbd_pkg::t_result i_item,
    output logic             o_pop,
    cbd_out_if.source        o_out
);

    logic             r_valid;
    cbd_pkg::t_result r_item;

    // Refill whenever the register is empty or being taken
    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
    end

    assign o_out.valid           = r_valid;
    assign o_out.request_kind    = r_item.request_kind;
    assign o_out.target          = r_item.target;
    assign o_out.request_address = r_item.request_address;
    assign o_out.request_data    = r_item.request_data;
    assign o_out.local_valid     = r_item.local_valid;
    assign o_out.local_data      = r_item.local_data;
    assign o_out.dma_active      = r_item.dma_active;

endmodule

// ----- sv/cpu_bus_decoder_with_oam_dma_core.sv -----
// Top level of the CPU bus decoder with sprite DMA and controller port.
//
// i_in carries CPU reads, CPU writes, DMA ticks and returned read data; every
// accepted item yields exactly one result item on o_out: a downstream request
// (RAM, PPU, APU or ROM), a locally answered read (work RAM, controller port,
// empty area) or an empty result, always with the DMA activity flag.
// Throughput is one item per cycle while i_in.ready is high; the front end
// decodes and updates state in the accept cycle. A result passes from its
// accepted item to o_out through the stage register that joins the registered
// work RAM read data, the queue, and the output register.
// When o_out stalls, the queue keeps taking items until its entries plus the
// stage register item reach the queue depth; then i_in.ready drops until
// space frees up. After reset a clearing pass writes zero to every work RAM
// entry, one per cycle; i_in.ready stays low during that pass.
module cpu_bus_decoder_with_oam_dma_core #(
    parameter int WORK_RAM_DEPTH = cbd_pkg::WORK_RAM_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cbd_in_if.sink     i_in,
    cbd_out_if.source  o_out
);

    localparam int CW = $clog2(cbd_pkg::QUEUE_DEPTH + 1);

    logic             push;
    cbd_pkg::t_result push_item;
    logic             q_valid;
    cbd_pkg::t_result q_item;
    logic             pop;
    logic [CW-1:0]    q_count;

    cbd_front #(
        .WORK_RAM_DEPTH(WORK_RAM_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_count(q_count),
        .o_push       (push),
        .o_item       (push_item)
    );

    cbd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_item (q_item),
        .o_count(q_count)
    );

    cbd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_item (q_item),
        .o_pop  (pop),
        .o_out  (o_out)
    );

endmodule

// ----- sv/cbd_checker.sv -----
// Port-level assertions for the CPU bus decoder, bound to the top level.
module cbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [1:0]  i_target,
    input logic [15:0] i_address,
    input logic [7:0]  i_data,
    input logic        i_local_valid,
    input logic [7:0]  i_local_data
);

    // Clearing pass blocks input right after reset
    a_clear_blocks_input: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_in_ready)
        else $error("input accepted during work RAM clearing");

    // Local answers never also issue a downstream request
    a_local_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_local_valid |-> i_kind == cbd_pkg::KIND_NONE)
        else $error("local answer with downstream request");

    // Empty request fields are zero when no request goes out
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == cbd_pkg::KIND_NONE |->
        i_target == 2'd0 && i_address == 16'd0 && i_data == 8'd0)
        else $error("request fields set without a request");

    // Local data is zero unless the read was answered here
    a_local_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_local_valid |-> i_local_data == 8'd0)
        else $error("local data without local answer");

    // Stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_address) &&
        $stable(i_kind))
        else $error("stalled result changed");

endmodule

bind cpu_bus_decoder_with_oam_dma_core cbd_checker u_cbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.request_kind),
    .i_target     (o_out.target),
    .i_address    (o_out.request_address),
    .i_data       (o_out.request_data),
    .i_local_valid(o_out.local_valid),
    .i_local_data (o_out.local_data)
);
